// ----- rtl/core/semq_pkg.sv -----
`timescale 1ns / 1ps

package semq_pkg;

	typedef logic [2:0]  func_t;
	typedef logic [1:0]  status_t;
	typedef logic [1:0]  action_t;
	typedef logic [7:0]  sem_id_t;
	typedef logic [15:0] pid_t;
	typedef logic [15:0] count_t;
	typedef logic [7:0]  ocnt_t;

	// request codes
	localparam func_t FUNC_OPEN      = 3'd0;
	localparam func_t FUNC_CLOSE     = 3'd1;
	localparam func_t FUNC_WAIT      = 3'd2;
	localparam func_t FUNC_WAIT_TICK = 3'd3;
	localparam func_t FUNC_POST      = 3'd4;
	localparam func_t FUNC_CLOSE_ALL = 3'd5;

	// status codes
	localparam status_t STAT_OK         = 2'd0;
	localparam status_t STAT_NOT_FOUND  = 2'd1;
	localparam status_t STAT_TABLE_FULL = 2'd2;
	localparam status_t STAT_QUEUE_FULL = 2'd3;

	// action codes
	localparam action_t ACT_NONE       = 2'd0;
	localparam action_t ACT_BLOCK      = 2'd1;
	localparam action_t ACT_BLOCK_TICK = 2'd2;
	localparam action_t ACT_UNBLOCK    = 2'd3;

	localparam count_t COUNT_MAX = 16'hFFFF;
	localparam ocnt_t  OCNT_MAX  = 8'hFF;

endpackage

// ----- rtl/core/semaphore_table_with_wait_queues.sv -----
`timescale 1ns / 1ps

// Semaphore table with FIFO wait queues.
// Request channel: drive func, sem_id, init_value and caller_pid with start
// high; the request is taken at a rising edge where start is high and busy is
// low. busy stays high until the result has been issued.
// Result channel: status, action, action_pid and opened_id are valid for the
// single cycle in which done is high. The receiver cannot stall; the outputs
// hold until the next request executes; a new one may be taken in that cycle.
// Search: the id search walks the entry table one row per cycle through one
// shared id comparator fed by the table RAM's read port; the sequencer then
// passes through drain and execute, and a post that releases a waiter adds
// one waiter RAM read state before done rises. The next request is taken at
// the edge that ends the done cycle; no request is accepted while busy, so
// a new request never overlaps the one in flight.
// Reset: arst_n low clears every valid bit and the sequencer; the table and
// waiter RAMs are not cleared and need no clearing pass, since a row's
// contents are only used after open has written it.

module semaphore_table_with_wait_queues #(
	parameter int NUM_SEMS    = 16,
	parameter int MAX_WAITERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  semq_pkg::func_t     func,
	input  semq_pkg::sem_id_t   sem_id,
	input  semq_pkg::count_t    init_value,
	input  semq_pkg::pid_t      caller_pid,
	output logic                done,
	output semq_pkg::status_t   status,
	output semq_pkg::action_t   action,
	output semq_pkg::pid_t      action_pid,
	output semq_pkg::sem_id_t   opened_id
);

	// slot index, queue position, queue fill and waiter address widths
	localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int QW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int TW  = $clog2(MAX_WAITERS + 1);
	localparam int PW  = TW + 1;
	localparam int WD  = NUM_SEMS * MAX_WAITERS;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
	// table row: {total, head, open count, count, id}
	localparam int RW  = TW + QW + 8 + 16 + 8;

	localparam logic [SW-1:0]  LAST_SLOT = SW'(NUM_SEMS - 1);
	localparam logic [TW-1:0]  Q_FULL    = TW'(MAX_WAITERS);
	localparam logic [PW-1:0]  Q_WRAP    = PW'(MAX_WAITERS);
	localparam logic [WAW-1:0] Q_STRIDE  = WAW'(MAX_WAITERS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_WRD   = 3'd4;

	logic [2:0] state_q;

	// latched request
	semq_pkg::func_t   func_q;
	semq_pkg::sem_id_t id_q;
	semq_pkg::count_t  init_q;
	semq_pkg::pid_t    pid_q;

	// scan pointer and compare stage
	logic [SW-1:0]       idx_q;
	logic                cmp_vld_s1;
	logic [SW-1:0]       cmp_idx_s1;
	logic                v_s1;
	logic [RW-1:0]       row_s1;
	logic [7:0]          r_id;
	semq_pkg::count_t    r_cnt;
	semq_pkg::ocnt_t     r_ocnt;
	logic [QW-1:0]       r_head;
	logic [TW-1:0]       r_tot;
	logic                hit;
	logic                empty_row;

	// search results and the matching row
	logic                found_q;
	logic [SW-1:0]       slot_q;
	logic                free_found_q;
	logic [SW-1:0]       free_q;
	semq_pkg::count_t    cur_cnt_q;
	semq_pkg::ocnt_t     cur_ocnt_q;
	logic [QW-1:0]       cur_head_q;
	logic [TW-1:0]       cur_tot_q;

	logic [NUM_SEMS-1:0] vld_q;

	// execute step
	logic                ent_we;
	logic [SW-1:0]       ent_waddr;
	logic [RW-1:0]       ent_wdata;
	logic [7:0]          w_id;
	semq_pkg::count_t    w_cnt;
	semq_pkg::ocnt_t     w_ocnt;
	logic [QW-1:0]       w_head;
	logic [TW-1:0]       w_tot;
	logic                vld_set;
	logic                vld_clr;
	logic                vld_clr_all;
	logic                wq_we;
	logic                need_rd;
	logic [PW-1:0]       pos_sum;
	logic [PW-1:0]       pos_wrap;
	logic [PW-1:0]       head_inc;
	logic [QW-1:0]       head_next;
	logic [WAW-1:0]      wq_base;
	logic [WAW-1:0]      wq_waddr;
	logic [WAW-1:0]      wq_raddr;
	semq_pkg::pid_t      wq_rdata;
	semq_pkg::status_t   st_n;
	semq_pkg::action_t   act_n;
	semq_pkg::pid_t      apid_n;
	semq_pkg::sem_id_t   opened_n;

	// result registers
	logic                done_q;
	semq_pkg::status_t   status_q;
	semq_pkg::action_t   action_q;
	semq_pkg::pid_t      apid_q;
	semq_pkg::sem_id_t   opened_q;

	assign busy = (state_q != S_IDLE);

	// ---------------------------------------------------------------------
	// Sequencer: accept, walk the table, execute, optionally fetch a waiter.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// advance one row per cycle; the last row is compared in drain
					if (idx_q == LAST_SLOT) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (need_rd) begin
						state_q <= S_WRD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_WRD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the request for the whole search
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			func_q <= func;
			id_q   <= sem_id;
			init_q <= init_value;
			pid_q  <= caller_pid;
		end
	end

	// ---------------------------------------------------------------------
	// Table RAM: read by the scan, written at most once by the execute step.
	// ---------------------------------------------------------------------
	semq_ram #(
		.DEPTH (NUM_SEMS),
		.WIDTH (RW),
		.AW    (SW)
	) u_table (
		.clk   (clk),
		.we    (ent_we && (state_q == S_EXEC)),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (idx_q),
		.rdata (row_s1)
	);

	assign {r_tot, r_head, r_ocnt, r_cnt, r_id} = row_s1;

	// compare stage lines up with the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		v_s1       <= vld_q[idx_q];
	end

	// the one shared comparator; ids are unique among valid rows
	assign hit       = cmp_vld_s1 && v_s1 && (r_id == id_q);
	assign empty_row = cmp_vld_s1 && !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == S_IDLE && start) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (hit) begin
				found_q <= 1'b1;
			end
			// keep the lowest free slot
			if (empty_row && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			slot_q     <= cmp_idx_s1;
			cur_cnt_q  <= r_cnt;
			cur_ocnt_q <= r_ocnt;
			cur_head_q <= r_head;
			cur_tot_q  <= r_tot;
		end
		if (empty_row && !free_found_q) begin
			free_q <= cmp_idx_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Execute: decide the result and the table and queue updates.
	// ---------------------------------------------------------------------
	// queue tail and next head wrap with one compare-subtract each
	assign pos_sum   = PW'(cur_head_q) + PW'(cur_tot_q);
	assign pos_wrap  = (pos_sum >= Q_WRAP) ? (pos_sum - Q_WRAP) : pos_sum;
	assign head_inc  = PW'(cur_head_q) + PW'(1);
	assign head_next = (head_inc == Q_WRAP) ? '0 : QW'(head_inc);
	assign wq_base   = WAW'(slot_q) * Q_STRIDE;
	assign wq_waddr  = wq_base + WAW'(QW'(pos_wrap));
	assign wq_raddr  = wq_base + WAW'(cur_head_q);

	always_comb begin
		ent_we      = 1'b0;
		ent_waddr   = slot_q;
		w_id        = id_q;
		w_cnt       = cur_cnt_q;
		w_ocnt      = cur_ocnt_q;
		w_head      = cur_head_q;
		w_tot       = cur_tot_q;
		vld_set     = 1'b0;
		vld_clr     = 1'b0;
		vld_clr_all = 1'b0;
		wq_we       = 1'b0;
		need_rd     = 1'b0;
		st_n        = semq_pkg::STAT_OK;
		act_n       = semq_pkg::ACT_NONE;
		apid_n      = '0;
		opened_n    = '0;
		unique case (func_q) inside
			semq_pkg::FUNC_OPEN: begin
				if (found_q) begin
					ent_we   = 1'b1;
					// saturate the open count
					w_ocnt   = (cur_ocnt_q == semq_pkg::OCNT_MAX) ? cur_ocnt_q
					           : cur_ocnt_q + 8'd1;
					opened_n = id_q;
				end else if (free_found_q) begin
					ent_we    = 1'b1;
					ent_waddr = free_q;
					vld_set   = 1'b1;
					w_cnt     = init_q;
					w_ocnt    = 8'd1;
					w_head    = '0;
					w_tot     = '0;
					opened_n  = id_q;
				end else begin
					st_n = semq_pkg::STAT_TABLE_FULL;
				end
			end
			semq_pkg::FUNC_CLOSE: begin
				if (!found_q) begin
					st_n = semq_pkg::STAT_NOT_FOUND;
				end else if (cur_ocnt_q > 8'd1) begin
					ent_we = 1'b1;
					w_ocnt = cur_ocnt_q - 8'd1;
				end else begin
					// drop the entry and any waiters with it
					vld_clr = 1'b1;
				end
			end
			semq_pkg::FUNC_WAIT, semq_pkg::FUNC_WAIT_TICK: begin
				if (!found_q) begin
					st_n = semq_pkg::STAT_NOT_FOUND;
				end else if (cur_cnt_q != '0) begin
					ent_we = 1'b1;
					w_cnt  = cur_cnt_q - 16'd1;
				end else if (cur_tot_q == Q_FULL) begin
					st_n = semq_pkg::STAT_QUEUE_FULL;
				end else begin
					ent_we = 1'b1;
					wq_we  = 1'b1;
					w_tot  = cur_tot_q + 1'b1;
					act_n  = (func_q == semq_pkg::FUNC_WAIT) ? semq_pkg::ACT_BLOCK
					         : semq_pkg::ACT_BLOCK_TICK;
					apid_n = pid_q;
				end
			end
			semq_pkg::FUNC_POST: begin
				if (!found_q) begin
					st_n = semq_pkg::STAT_NOT_FOUND;
				end else if (cur_tot_q != '0) begin
					// release the oldest waiter; its pid arrives next cycle
					ent_we  = 1'b1;
					need_rd = 1'b1;
					w_head  = head_next;
					w_tot   = cur_tot_q - 1'b1;
					act_n   = semq_pkg::ACT_UNBLOCK;
				end else if (cur_cnt_q != semq_pkg::COUNT_MAX) begin
					ent_we = 1'b1;
					w_cnt  = cur_cnt_q + 16'd1;
				end
			end
			semq_pkg::FUNC_CLOSE_ALL: begin
				vld_clr_all = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ent_wdata = {w_tot, w_head, w_ocnt, w_cnt, w_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (state_q == S_EXEC) begin
			if (vld_clr_all) begin
				vld_q <= '0;
			end else if (vld_set) begin
				vld_q[free_q] <= 1'b1;
			end else if (vld_clr) begin
				vld_q[slot_q] <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Waiter RAM: one circular queue of MAX_WAITERS pids per slot.
	// ---------------------------------------------------------------------
	semq_ram #(
		.DEPTH (WD),
		.WIDTH (16),
		.AW    (WAW)
	) u_waiters (
		.clk   (clk),
		.we    (wq_we && (state_q == S_EXEC)),
		.waddr (wq_waddr),
		.wdata (pid_q),
		.raddr (wq_raddr),
		.rdata (wq_rdata)
	);

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_q <= st_n;
			action_q <= act_n;
			apid_q   <= apid_n;
			opened_q <= opened_n;
		end else if (state_q == S_WRD) begin
			apid_q <= wq_rdata;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign action     = action_q;
	assign action_pid = apid_q;
	assign opened_id  = opened_q;

endmodule

// ----- rtl/core/semq_ram.sv -----
`timescale 1ns / 1ps

module semq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
